// ===== rtl/sorted_insert_list_defines.svh =====
// Assertion macros shared by the sorted insertion list RTL.
`ifndef SORTED_INSERT_LIST_DEFINES_SVH
`define SORTED_INSERT_LIST_DEFINES_SVH
`ifndef SYNTHESIS
// Condition and consequence checked in the same cycle.
`define SIL_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);
// Consequence checked in the cycle after the condition.
`define SIL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define SIL_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg)
`define SIL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ===== rtl/sil_pkg.sv =====
// Types, codes and helpers shared by the sorted insertion list modules.
`default_nettype none
package sil_pkg;

  // One stored list entry.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] tag;
  } sil_entry_t;

  // What one cell hands to its right neighbor every cycle.
  typedef struct packed {
    logic       after;   // new key goes at or before this cell
    sil_entry_t entry;   // entry held by this cell
  } sil_link_t;

  // Item kinds carried in tuser.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Configuration register index (paddr[2]) and reset value.
  localparam logic       REG_CAPACITY_IN_USE = 1'b0;
  localparam logic [6:0] CAPACITY_RESET      = 7'd64;

  // Read path: entries are gathered in groups of eight lanes.
  localparam int LANES  = 8;
  localparam int GROUPS = 8;

  // Signed compare of two Q16.16 keys: a < b.
  function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sil_cell.sv =====
// One compare-and-shift cell of the sorted list chain.
`default_nettype none
module sil_cell
  import sil_pkg::*;
(
  input  wire        clk,
  input  wire        ins_en,
  input  wire        occupied,
  input  sil_entry_t new_entry,
  input  sil_link_t  left,
  output sil_link_t  right
);

  sil_entry_t stored;
  logic       after;

  // The new key lands here or to the left when this slot is empty or
  // holds a strictly greater key.
  always_comb begin
    after = !occupied || key_less(new_entry.key, stored.key);
  end

  // On insert, shift in the left neighbor's entry, or take the new one
  // where the left neighbor stays in place.
  always_ff @(posedge clk) begin
    if (ins_en && after) begin
      stored <= left.after ? left.entry : new_entry;
    end
  end

  assign right.after = after;
  assign right.entry = stored;

endmodule
`default_nettype wire

// ===== rtl/sil_rd_group.sv =====
// Registered eight-lane select for the read path of the sorted list.
`default_nettype none
module sil_rd_group
  import sil_pkg::*;
(
  input  wire                          clk,
  input  wire                          en,
  input  wire  [$clog2(LANES)-1:0]     lane_sel,
  input  sil_entry_t [LANES-1:0]       lanes,
  output sil_entry_t                   q
);

  // Capture the chosen lane when a read is taken.
  always_ff @(posedge clk) begin
    if (en) begin
      q <= lanes[lane_sel];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_insert_list.sv =====
// Top level of the sorted insertion list: cell chain, read select and handshakes.
//
// Usage: items arrive on the s_axis channel, tuser carrying the kind (insert or
// read) and tdata the key, tag and read index. Each item gives exactly one
// result on the m_axis channel, tuser carrying the status and tdata the entry
// count, key and tag. An insert is placed by the row of compare-and-shift
// cells, so its result is valid in the cycle after the transfer. A read
// passes a registered eight-way lane select and then a group select into the
// output register. One item is in flight at a time: inserts can be taken every
// cycle while results are taken; a read blocks input in its select state.
// The result sits in an output register; the next item is taken while that
// register is empty or being emptied, so a stalled receiver holds off new input
// without losing anything. The capacity_in_use register is written over the
// APB port and should only change while no item is in flight. Reset empties
// the list and sets capacity_in_use to 64; stored entries keep stale contents
// that are never shown.
`default_nettype none
`include "sorted_insert_list_defines.svh"
module sorted_insert_list
  import sil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst,
  // Input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,   // key[31:0], tag[63:32], read_index[69:64]
  input  wire         s_axis_tuser,   // mode
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // stored_count[6:0], key_out[38:7], tag_out[70:39]
  output logic [1:0]  m_axis_tuser,   // status
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int LN_W  = $clog2(LANES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEL  = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic [6:0]       capacity_in_use;
  logic             rd_ok;
  logic [2:0]       rd_hi;
  logic             m_valid;
  logic [1:0]       m_status;
  logic [6:0]       m_count;
  sil_entry_t       m_entry;

  logic             in_xfer, out_xfer, ins_acc, rd_acc, full, ins_en, ridx_ok;
  logic [LIM_W-1:0] cap_ext, cap_lim, count_ext, count_inc;
  logic [5:0]       ridx;
  sil_entry_t       new_entry;

  sil_link_t                   link [CAPACITY];
  logic      [CAPACITY-1:0]    occ;
  sil_entry_t [LANES-1:0]      lanes [GROUPS];
  sil_entry_t                  grp_q [GROUPS];

  // Input fields and handshake decode.
  assign new_entry.key = s_axis_tdata[31:0];
  assign new_entry.tag = s_axis_tdata[63:32];
  assign ridx          = s_axis_tdata[69:64];

  assign s_axis_tready = (state == ST_IDLE) && (!m_valid || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_valid && m_axis_tready;
  assign ins_acc       = in_xfer && (s_axis_tuser == MODE_INSERT);
  assign rd_acc        = in_xfer && (s_axis_tuser == MODE_READ);

  // Fill limit is the register value saturated to the cell count.
  assign cap_ext   = LIM_W'(capacity_in_use);
  assign cap_lim   = (cap_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cap_ext;
  assign count_ext = LIM_W'(count);
  assign count_inc = count_ext + LIM_W'(1);
  assign full      = count_ext >= cap_lim;
  assign ins_en    = ins_acc && !full;
  assign ridx_ok   = LIM_W'(ridx) < count_ext;

  // Chain of cells; each knows from the count whether it holds an entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sil_link_t left_in;
    assign occ[i] = CNT_W'(i) < count;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_rest
      assign left_in = link[i-1];
    end
    sil_cell u_cell (
      .clk       (clk),
      .ins_en    (ins_en),
      .occupied  (occ[i]),
      .new_entry (new_entry),
      .left      (left_in),
      .right     (link[i])
    );
  end

  // Read path: the first 64 cells in eight groups of eight lanes.
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (g * LANES + l < CAPACITY) begin : g_used
        assign lanes[g][l] = link[g * LANES + l].entry;
      end else begin : g_pad
        assign lanes[g][l] = '0;
      end
    end
    sil_rd_group u_grp (
      .clk      (clk),
      .en       (rd_acc),
      .lane_sel (ridx[LN_W-1:0]),
      .lanes    (lanes[g]),
      .q        (grp_q[g])
    );
  end

  // Sequencer: a read waits in the select state for the group select.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_acc) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ins_en) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Read bookkeeping latched with the transfer.
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      rd_ok <= ridx_ok;
      rd_hi <= ridx[5:3];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ins_acc || (state == ST_SEL)) begin
      m_valid <= 1'b1;
    end else if (out_xfer) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_acc) begin
      m_status <= full ? ST_FULL : ST_OK;
      m_count  <= full ? count_ext[6:0] : count_inc[6:0];
      m_entry  <= '0;
    end else if (state == ST_SEL) begin
      m_status <= rd_ok ? ST_OK : ST_EMPTY;
      m_count  <= count_ext[6:0];
      m_entry  <= rd_ok ? grp_q[rd_hi] : '0;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = m_status;
  assign m_axis_tdata  = {1'b0, m_entry.tag, m_entry.key, m_count};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY_IN_USE)) begin
      capacity_in_use <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY_IN_USE) ? {25'd0, capacity_in_use} : 32'd0;

  // Checks on the list control.
  `SIL_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `SIL_ASSERT_NEXT(a_count_step, clk, rst, ins_en, (count - $past(count)) == CNT_W'(1), "insert did not add one entry")
  `SIL_ASSERT_NEXT(a_read_seq, clk, rst, rd_acc, state == ST_SEL && !s_axis_tready, "read did not enter select cycle")
  `SIL_ASSERT_SAME(a_no_overwrite, clk, rst, s_axis_tready, !m_valid || m_axis_tready, "input taken while result blocked")

endmodule
`default_nettype wire

// ===== tb/tb_sorted_insert_list.sv =====
// Self-checking testbench for the sorted insertion list: directed table, then random phases.
`timescale 1ns / 100ps
module tb_sorted_insert_list;
  import sil_pkg::*;

  localparam int LIST_DEPTH       = 64;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 230;
  localparam int NUM_PHASES       = 8;

  // One input item and one result, at the block's field widths.
  typedef struct packed {
    logic        mode;
    logic [31:0] key;
    logic [31:0] tag;
    logic [5:0]  ridx;
  } list_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] key;
    logic [31:0] tag;
  } list_result_t;

  // A row of the directed table: either a register write or an item.
  typedef struct packed {
    bit           is_cfg;
    logic [2:0]   addr;
    logic [31:0]  wdata;
    list_op_t     op;
    bit           known;
    list_result_t res;
  } stim_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // key[31:0], tag[63:32], read_index[69:64]
  logic        s_axis_tuser;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // stored_count[6:0], key_out[38:7], tag_out[70:39]
  logic [1:0]  m_axis_tuser;   // status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the list and its register.
  logic [31:0] held_keys [LIST_DEPTH];
  logic [31:0] held_tags [LIST_DEPTH];
  int          held_count;
  logic [6:0]  capacity_model;

  list_result_t pending_results[$];
  int           mismatches;
  idle_mode_t   idle_mode;
  bit           long_hold_req;
  int           long_hold_left;

  sorted_insert_list uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one item to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t r;
    int limit;
    int pos;
    r = '0;
    if (op.mode == MODE_INSERT) begin
      limit = (capacity_model > LIST_DEPTH) ? LIST_DEPTH : int'(capacity_model);
      if (held_count >= limit) begin
        r.status = ST_FULL;
      end else begin
        // The new entry goes before the first strictly greater key.
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--)
          if ($signed(op.key) < $signed(held_keys[i])) pos = i;
        for (int i = held_count; i > pos; i--) begin
          held_keys[i] = held_keys[i - 1];
          held_tags[i] = held_tags[i - 1];
        end
        held_keys[pos] = op.key;
        held_tags[pos] = op.tag;
        held_count++;
        r.status = ST_OK;
      end
    end else if (op.ridx < held_count) begin
      r.status = ST_OK;
      r.key    = held_keys[op.ridx];
      r.tag    = held_tags[op.ridx];
    end else begin
      r.status = ST_EMPTY;
    end
    r.count = held_count[6:0];
    return r;
  endfunction

  // Random item: keys lean toward duplicates, extremes and values near zero.
  function automatic list_op_t random_op();
    list_op_t o;
    int sel;
    o.mode = ($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_READ;
    o.tag  = $urandom;
    sel    = $urandom_range(0, 9);
    if (sel < 2 && held_count > 0)
      o.key = held_keys[$urandom_range(0, held_count - 1)];
    else if (sel == 2)
      case ($urandom_range(0, 3))
        0: o.key = 32'h7FFF_FFFF;
        1: o.key = 32'h8000_0000;
        2: o.key = 32'h0000_0000;
        default: o.key = 32'hFFFF_FFFF;
      endcase
    else if (sel == 3)
      o.key = $signed($urandom_range(0, 15) - 8) <<< 16;
    else
      o.key = $urandom;
    if ($urandom_range(0, 3) == 0)
      o.ridx = 6'($urandom_range(0, 63));
    else
      o.ridx = (held_count > 63) ? 6'd63 : 6'($urandom_range(0, held_count));
    return o;
  endfunction

  function automatic bit send_gap();
    return (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 45) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 30);
  endfunction

  function automatic bit recv_stall();
    return (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 45) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 30);
  endfunction

  function automatic stim_row_t item_row(input logic mode, input logic [31:0] key,
                                         input logic [31:0] tag, input logic [5:0] ridx);
    stim_row_t r;
    r = '0;
    r.op = '{mode: mode, key: key, tag: tag, ridx: ridx};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic mode, input logic [31:0] key,
                                          input logic [31:0] tag, input logic [5:0] ridx,
                                          input logic [1:0] status, input logic [6:0] count,
                                          input logic [31:0] kout, input logic [31:0] tout);
    stim_row_t r;
    r       = item_row(mode, key, tag, ridx);
    r.known = 1'b1;
    r.res   = '{status: status, count: count, key: kout, tag: tout};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] addr, input logic [31:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.wdata  = data;
    return r;
  endfunction

  // Offers one item until a transfer happens, then records its expected result.
  // Entered and left at a falling edge.
  task automatic push_item(input list_op_t op, input bit known, input list_result_t given);
    list_result_t predicted;
    while (send_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.mode;
    s_axis_tdata  <= {2'b00, op.ridx, op.tag, op.key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_list_op(op);
    pending_results.insert(pending_results.size(), known ? given : predicted);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Register write followed by a read-back of the capacity register.
  task automatic write_config(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_CAPACITY_IN_USE) capacity_model = data[6:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_CAPACITY_IN_USE, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {25'd0, capacity_model}) begin
      mismatches++;
      $display("%0t: capacity register mismatch: expected %h, got %h",
               $time, {25'd0, capacity_model}, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_left = LONG_HOLD_CYCLES;
      long_hold_req  = 1'b0;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !recv_stall();
    end
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, count: m_axis_tdata[6:0],
              key: m_axis_tdata[38:7], tag: m_axis_tdata[70:39]};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no expectation: expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("stored_count", 32'(want.count), 32'(got.count));
        check_field("key_out", want.key, got.key);
        check_field("tag_out", want.tag, got.tag);
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("** sorted_insert_list: FAILED **");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed[$];
    int phase_caps[NUM_PHASES];
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    held_count     = 0;
    capacity_model = CAPACITY_RESET;
    mismatches     = 0;
    idle_mode      = IDLE_NONE;
    long_hold_req  = 1'b0;
    long_hold_left = 0;
    phase_caps     = '{6, 16, 0, 30, 45, 64, 100, 127};

    // Directed part: empty reads, zero capacity, the ignored register index,
    // key extremes with equal keys, a lowered capacity and the saturated one.
    directed = '{
      known_row(MODE_READ,   32'h0,        32'h0,        6'd0,  ST_EMPTY, 7'd0, 32'h0, 32'h0),
      known_row(MODE_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, ST_EMPTY, 7'd0, 32'h0, 32'h0),
      cfg_row(3'd0, 32'd0),
      known_row(MODE_INSERT, 32'h7FFF_FFFF, 32'h1,        6'd0,  ST_FULL,  7'd0, 32'h0, 32'h0),
      cfg_row(3'd4, 32'd5),
      known_row(MODE_INSERT, 32'h1234_5678, 32'h2,        6'd63, ST_FULL,  7'd0, 32'h0, 32'h0),
      cfg_row(3'd0, 32'hFFFF_FF83),
      known_row(MODE_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0, ST_OK,    7'd1, 32'h0, 32'h0),
      known_row(MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 6'd0, ST_OK,    7'd2, 32'h0, 32'h0),
      known_row(MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, ST_OK,    7'd3, 32'h0, 32'h0),
      known_row(MODE_INSERT, 32'h0,        32'h0,        6'd63, ST_FULL,  7'd3, 32'h0, 32'h0),
      known_row(MODE_READ,   32'h0,        32'h0,        6'd0,  ST_OK,    7'd3,
                32'h8000_0000, 32'h8000_0000),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd1),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd2),
      known_row(MODE_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd3, ST_EMPTY, 7'd3, 32'h0, 32'h0),
      known_row(MODE_READ,   32'h0,        32'h0,        6'd63, ST_EMPTY, 7'd3, 32'h0, 32'h0),
      cfg_row(3'd0, 32'd1),
      known_row(MODE_INSERT, 32'h0,        32'h0,        6'd0,  ST_FULL,  7'd3, 32'h0, 32'h0),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd2),
      cfg_row(3'd0, 32'd127),
      item_row(MODE_INSERT,  32'h0000_0000, 32'hAAAA_AAAA, 6'd0),
      item_row(MODE_INSERT,  32'hFFFF_FFFF, 32'h5555_5555, 6'd0),
      item_row(MODE_INSERT,  32'h0001_0000, 32'h0000_0001, 6'd0),
      item_row(MODE_INSERT,  32'h8000_0000, 32'h0,        6'd0),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd1),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd4),
      item_row(MODE_READ,    32'h0,        32'h0,        6'd6)
    };

    // Reset once, then start driving at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_config(directed[i].addr, directed[i].wdata);
      end else begin
        push_item(directed[i].op, directed[i].known, directed[i].res);
      end
    end

    // Random phases: each sets a capacity, then runs under one idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_config({REG_CAPACITY_IN_USE, 2'b00},
                   ($urandom & 32'hFFFF_FF80) | 32'(phase_caps[p]));
      idle_mode = idle_mode_t'(p % 4);
      if (p == 1) begin
        // Hold off the receiver while items keep coming, so input backs up.
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        push_item(random_op(), 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("** sorted_insert_list: PASSED **");
    end else begin
      $display("** sorted_insert_list: FAILED **");
    end
    $finish;
  end

endmodule
